// ===== sv/swmh_pkg.sv =====
// Shared types and constants for the sliding window minimum hash unit.
package swmh_pkg;

  localparam int HASH_W         = 64;
  localparam int WSIZE_W        = 7;
  localparam int WINDOW_MAX_DEF = 64;

  // Register indexes on the configuration port
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Per-cycle command to every cell of the window chain
  typedef struct packed {
    logic shift;   // take the neighbor on the newer side, new hash enters cell 0
    logic rotate;  // take the neighbor on the older side, ring closed
  } swmh_cell_ctl_t;

endpackage

// ===== sv/sliding_window_min_hash_unit.sv =====
// Top level of the sliding window minimum hash unit (minimizer over a hash stream).
//
// Usage:
//   in_*  : stream of 64-bit k-mer hashes, in_tdata[63:0] = hash, in_tlast marks
//           the last hash of a read. One result transaction per input transaction.
//   out_* : out_tdata[63:0] = window minimum, [64] = window full, [65] = new
//           minimum, rest zero; out_tlast echoes the read end of the input.
//   cfg_* : APB write/read of window_size at byte address 0 (reset value 1).
//           Zero acts as 1, values above WINDOW_MAX act as WINDOW_MAX; only cfg_pwdata[6:0] is stored.
//   The window is a chain of WINDOW_MAX cells. An accepted hash shifts in at
//   cell 0; then the ring rotates once around while a single 64-bit compare
//   at cell 0 folds the newest window_size entries into the minimum; then the
//   output register is loaded once it is free. A new hash is taken only in the
//   idle state, after the previous result has entered the output register, so
//   the transaction rate is set by the ring rotation through the single compare
//   unit.
//   Reset: read state cleared, window_size = 1, cell contents left undefined.
//   Stall: a finished result waits in the output register; the next hash is
//   taken and worked on meanwhile, and its result waits until the slot frees.
module sliding_window_min_hash_unit
  import swmh_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,   // [63:0] hash_value
  input  logic               in_tlast,   // read_end
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata,  // [63:0] window_minimum, [64] window_full,
                                         // [65] new_minimum, [71:66] zero
  output logic               out_tlast,  // last_of_read
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CW    = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [WSIZE_W-1:0] window_size_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WSIZE_W'(1);
    end else if (cfg_wr && (cfg_paddr[2] == REG_WINDOW_SIZE)) begin
      window_size_r <= cfg_pwdata[WSIZE_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_WINDOW_SIZE) begin
      cfg_prdata = 32'(window_size_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // effective window: zero acts as one, saturate at WINDOW_MAX
  logic [CW-1:0]    ws_ext;
  logic [CNT_W-1:0] eff_w;

  assign ws_ext = CW'(window_size_r);

  always_comb begin
    if (ws_ext == '0) begin
      eff_w = CNT_W'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      eff_w = CNT_W'(WINDOW_MAX);
    end else begin
      eff_w = CNT_W'(ws_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic [CNT_W-1:0]  seen_r;
  logic [CNT_W-1:0]  seen_inc;
  logic [CNT_W-1:0]  win_r;       // window length latched at accept
  logic              full_r;
  logic              last_r;
  logic [HASH_W-1:0] acc_r;       // running minimum over the scan
  logic [HASH_W-1:0] prev_min_r;
  logic              prev_valid_r;
  logic              in_xfer;
  logic              out_load;
  logic              scan_end;
  logic              fresh;
  logic [HASH_W-1:0] head;

  logic              out_tvalid_r;
  logic [HASH_W-1:0] out_min_r;
  logic              out_full_r;
  logic              out_new_r;
  logic              out_last_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign scan_end  = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(WINDOW_MAX - 1));
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  assign seen_inc  = (seen_r < CNT_W'(WINDOW_MAX)) ? seen_r + CNT_W'(1) : seen_r;
  // first full window of the read, or minimum moved
  assign fresh     = full_r && (!prev_valid_r || (acc_r != prev_min_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer)  state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      seen_r       <= '0;
      prev_min_r   <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        scan_cnt_r <= '0;
        seen_r     <= seen_inc;
      end else if (state_r == ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        if (last_r) begin
          seen_r       <= '0;
          prev_min_r   <= '0;
          prev_valid_r <= 1'b0;
        end else if (full_r) begin
          prev_min_r   <= acc_r;
          prev_valid_r <= 1'b1;
        end
      end
    end
  end

  // per-item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_r  <= eff_w;
      full_r <= (seen_inc >= eff_w);
      last_r <= in_tlast;
      acc_r  <= '1;
    end else if ((state_r == ST_SCAN) && (scan_cnt_r < win_r) && (head < acc_r)) begin
      acc_r  <= head;
    end
  end

  // ---------------------------------------------------------------------------
  // Window chain: shift on accept, rotate once around during the scan
  // ---------------------------------------------------------------------------
  swmh_cell_ctl_t    cell_ctl;
  logic [HASH_W-1:0] cell_q [WINDOW_MAX];

  assign cell_ctl.shift  = in_xfer;
  assign cell_ctl.rotate = (state_r == ST_SCAN);
  assign head            = cell_q[0];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swmh_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .shift_in  ((i == 0) ? in_tdata : cell_q[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
      .rotate_in (cell_q[(i + 1) % WINDOW_MAX]),
      .data_out  (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r  <= full_r ? acc_r : '0;
      out_full_r <= full_r;
      out_new_r  <= fresh;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_new_r, out_full_r, out_min_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[64]) |-> ((out_tdata[63:0] == '0) && !out_tdata[65]))
    else $error("result without full window carries a minimum or new flag");

  a_read_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> ((seen_r == '0) && !prev_valid_r))
    else $error("read state not cleared after end of read");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r < CNT_W'(WINDOW_MAX)))
    else $error("scan counter past end of chain");

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(WINDOW_MAX))
    else $error("hash count above WINDOW_MAX");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> ((state_r == ST_SCAN) && (scan_cnt_r == '0)))
    else $error("accepted transaction did not start a scan");

endmodule

// ===== sv/swmh_cell.sv =====
// One window cell: holds a hash and passes it along the chain.
module swmh_cell
  import swmh_pkg::*;
(
  input  logic                  clk,
  input  swmh_cell_ctl_t        ctl,
  input  logic [HASH_W-1:0]     shift_in,
  input  logic [HASH_W-1:0]     rotate_in,
  output logic [HASH_W-1:0]     data_out
);

  logic [HASH_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= shift_in;
    end else if (ctl.rotate) begin
      data_r <= rotate_in;
    end
  end

  assign data_out = data_r;

endmodule
